// ===== src/rgb_to_hsv_pixel_macros.svh =====
// Assertion macros for the RGB to HSV pixel converter.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

// Implication checked on every clock, skipped while in reset.
`define RGBHSV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain condition checked on every clock, skipped while in reset.
`define RGBHSV_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== src/rgbhsv_pkg.sv =====
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies; used by all rgbhsv modules.
package rgbhsv_pkg;

  localparam int PIX_W      = 8;
  localparam int RCP_SHIFT  = 24;
  localparam int RCP_W      = RCP_SHIFT + 1;
  localparam int SNUM_W     = 2 * PIX_W;
  localparam int HNUM_W     = 13;
  localparam int SPROD_W    = SNUM_W + RCP_W;
  localparam int HPROD_W    = HNUM_W + RCP_W;
  localparam int RCP_DEPTH  = 1 << PIX_W;

  localparam int SAT_SCALE  = 255;
  localparam int HUE_SCALE  = 30;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [RCP_W-1:0]   rcp_t;
  typedef logic [SNUM_W-1:0]  snum_t;
  typedef logic [HNUM_W-1:0]  hnum_t;
  typedef logic [SPROD_W-1:0] sprod_t;
  typedef logic [HPROD_W-1:0] hprod_t;

  // Half of the hue base angle for each sector
  localparam pix_t HBASE_RED_POS = pix_t'(0);
  localparam pix_t HBASE_RED_NEG = pix_t'(180);
  localparam pix_t HBASE_GREEN   = pix_t'(60);
  localparam pix_t HBASE_BLUE    = pix_t'(120);

  typedef struct packed {
    pix_t mx;
    pix_t d;
    pix_t hbase;
    pix_t adiff;
    logic neg;
  } prep_t;

  typedef struct packed {
    snum_t sat_num;
    hnum_t hue_num;
    rcp_t  rcp_mx;
    rcp_t  rcp_d;
    pix_t  hbase;
    pix_t  mx;
    logic  neg;
  } scaled_t;

  typedef struct packed {
    sprod_t sat_prod;
    hprod_t hue_prod;
    pix_t   hbase;
    pix_t   mx;
    logic   neg;
  } prod_t;

endpackage

// ===== src/rgbhsv_prep.sv =====
// Stage A: max/min search, spread and hue sector selection.
// Depends on rgbhsv_pkg.
module rgbhsv_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rgbhsv_pkg::pix_t   red,
  input  rgbhsv_pkg::pix_t   green,
  input  rgbhsv_pkg::pix_t   blue,
  output logic               out_valid,
  input  logic               out_ready,
  output rgbhsv_pkg::prep_t  out_data
);

  logic              valid_r;
  rgbhsv_pkg::prep_t data_r;
  rgbhsv_pkg::prep_t data_nxt;
  logic              r_max;
  logic              g_max;
  rgbhsv_pkg::pix_t  mx;
  rgbhsv_pkg::pix_t  mn;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    r_max = (red >= green) && (red >= blue);
    g_max = !r_max && (green >= blue);
    mx = r_max ? red : (g_max ? green : blue);
    if (red <= green && red <= blue) begin
      mn = red;
    end else if (green <= blue) begin
      mn = green;
    end else begin
      mn = blue;
    end
    data_nxt.mx = mx;
    data_nxt.d  = mx - mn;
    if (r_max) begin
      if (blue > green) begin
        data_nxt.neg   = 1'b1;
        data_nxt.hbase = rgbhsv_pkg::HBASE_RED_NEG;
        data_nxt.adiff = blue - green;
      end else begin
        data_nxt.neg   = 1'b0;
        data_nxt.hbase = rgbhsv_pkg::HBASE_RED_POS;
        data_nxt.adiff = green - blue;
      end
    end else if (g_max) begin
      data_nxt.hbase = rgbhsv_pkg::HBASE_GREEN;
      data_nxt.neg   = red > blue;
      data_nxt.adiff = (red > blue) ? red - blue : blue - red;
    end else begin
      data_nxt.hbase = rgbhsv_pkg::HBASE_BLUE;
      data_nxt.neg   = green > red;
      data_nxt.adiff = (green > red) ? green - red : red - green;
    end
    // gray or black: hue forced to zero; saturation is zero since d is zero
    if (data_nxt.d == '0) begin
      data_nxt.hbase = '0;
      data_nxt.neg   = 1'b0;
      data_nxt.adiff = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== src/rgbhsv_div.sv =====
// Stages B and C: reciprocal lookup, numerator scaling, then the two products.
// Depends on rgbhsv_pkg.
module rgbhsv_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rgbhsv_pkg::prep_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rgbhsv_pkg::prod_t   out_data
);

  rgbhsv_pkg::rcp_t    rcp_tab [rgbhsv_pkg::RCP_DEPTH];
  logic                b_valid_r;
  rgbhsv_pkg::scaled_t b_data_r;
  rgbhsv_pkg::scaled_t b_data_nxt;
  logic                b_ready;
  logic                c_valid_r;
  rgbhsv_pkg::prod_t   c_data_r;
  rgbhsv_pkg::prod_t   c_data_nxt;
  logic                c_ready;

  // ceil(2^RCP_SHIFT / v): exact floor quotient for numerators below 2^16
  for (genvar gi = 0; gi < rgbhsv_pkg::RCP_DEPTH; gi++) begin : g_rcp
    localparam longint unsigned DIVISOR = (gi == 0) ? 1 : gi;
    localparam longint unsigned RCP_VAL =
      (gi == 0) ? 0 : ((64'd1 << rgbhsv_pkg::RCP_SHIFT) + DIVISOR - 1) / DIVISOR;
    assign rcp_tab[gi] = rgbhsv_pkg::rcp_t'(RCP_VAL);
  end

  assign b_ready   = !b_valid_r || c_ready;
  assign c_ready   = !c_valid_r || out_ready;
  assign in_ready  = b_ready;
  assign out_valid = c_valid_r;
  assign out_data  = c_data_r;

  always_comb begin
    b_data_nxt.sat_num = rgbhsv_pkg::snum_t'(in_data.d) *
                         rgbhsv_pkg::snum_t'(rgbhsv_pkg::SAT_SCALE);
    // negative sectors need ceil, so bias by d-1
    b_data_nxt.hue_num = rgbhsv_pkg::hnum_t'(in_data.adiff) *
                         rgbhsv_pkg::hnum_t'(rgbhsv_pkg::HUE_SCALE) +
                         (in_data.neg ? rgbhsv_pkg::hnum_t'(in_data.d - 8'd1) : '0);
    b_data_nxt.rcp_mx  = rcp_tab[in_data.mx];
    b_data_nxt.rcp_d   = rcp_tab[in_data.d];
    b_data_nxt.hbase   = in_data.hbase;
    b_data_nxt.mx      = in_data.mx;
    b_data_nxt.neg     = in_data.neg;
  end

  always_comb begin
    c_data_nxt.sat_prod = rgbhsv_pkg::sprod_t'(b_data_r.sat_num) *
                          rgbhsv_pkg::sprod_t'(b_data_r.rcp_mx);
    c_data_nxt.hue_prod = rgbhsv_pkg::hprod_t'(b_data_r.hue_num) *
                          rgbhsv_pkg::hprod_t'(b_data_r.rcp_d);
    c_data_nxt.hbase    = b_data_r.hbase;
    c_data_nxt.mx       = b_data_r.mx;
    c_data_nxt.neg      = b_data_r.neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid_r <= in_valid;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && b_ready) begin
      b_data_r <= b_data_nxt;
    end
    if (b_valid_r && c_ready) begin
      c_data_r <= c_data_nxt;
    end
  end

endmodule

// ===== src/rgbhsv_out.sv =====
// Stage D: quotient extraction, hue assembly and the output register.
// Depends on rgbhsv_pkg.
module rgbhsv_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rgbhsv_pkg::prod_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rgbhsv_pkg::pix_t   hue,
  output rgbhsv_pkg::pix_t   saturation,
  output rgbhsv_pkg::pix_t   brightness
);

  logic             valid_r;
  rgbhsv_pkg::pix_t hue_r;
  rgbhsv_pkg::pix_t sat_r;
  rgbhsv_pkg::pix_t bright_r;
  rgbhsv_pkg::pix_t hue_nxt;
  rgbhsv_pkg::pix_t sat_nxt;
  rgbhsv_pkg::pix_t hq;

  assign in_ready   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign hue        = hue_r;
  assign saturation = sat_r;
  assign brightness = bright_r;

  always_comb begin
    sat_nxt = in_data.sat_prod[rgbhsv_pkg::RCP_SHIFT +: rgbhsv_pkg::PIX_W];
    hq      = in_data.hue_prod[rgbhsv_pkg::RCP_SHIFT +: rgbhsv_pkg::PIX_W];
    hue_nxt = in_data.neg ? in_data.hbase - hq : in_data.hbase + hq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= in_data.mx;
    end
  end

endmodule

// ===== src/rgb_to_hsv_pixel.sv =====
// RGB to HSV pixel converter, top level: four register stages A..D.
// Each pixel is registered in stages A, B, C and D in order before its output transaction.
// Throughput: one pixel per cycle while out_tready is high; the stall chain is per-stage ready.
// Divisions use a 256-entry reciprocal table and one multiply per quotient.
// Reset (rst_n low, synchronous) clears all stage valid bits; no clearing pass.
// Depends on rgbhsv_pkg, rgbhsv_prep, rgbhsv_div, rgbhsv_out and the macro header.
`include "rgb_to_hsv_pixel_macros.svh"

module rgb_to_hsv_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // hue[7:0], saturation[15:8], brightness[23:16]
);

  logic              a_valid;
  logic              a_ready;
  rgbhsv_pkg::prep_t a_data;
  logic              c_valid;
  logic              c_ready;
  rgbhsv_pkg::prod_t c_data;
  rgbhsv_pkg::pix_t  hue;
  rgbhsv_pkg::pix_t  saturation;
  rgbhsv_pkg::pix_t  brightness;

  rgbhsv_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_data  (a_data)
  );

  rgbhsv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_data   (a_data),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_data  (c_data)
  );

  rgbhsv_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (c_valid),
    .in_ready   (c_ready),
    .in_data    (c_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  assign out_tdata = {brightness, saturation, hue};

  `RGBHSV_ASSERT_IMP(a_hue_range, out_tvalid, hue < 8'd180, "hue out of range")
  `RGBHSV_ASSERT_IMP(a_gray_hue, out_tvalid && saturation == 8'd0, hue == 8'd0,
                     "nonzero hue on gray pixel")
  `RGBHSV_ASSERT_IMP(a_black_sat, out_tvalid && brightness == 8'd0, saturation == 8'd0,
                     "nonzero saturation on black pixel")
  `RGBHSV_ASSERT_ALWAYS(a_stall_cause, in_tready || (out_tvalid && !out_tready),
                        "input stalled without output back-pressure")

endmodule
